@@ rtl/core/frf_pkg.sv @@
// frf_pkg: shared constants, codes and item types of the fragment reassembly fifo
// depends on nothing; imported by the channel interfaces, frf_ctrl, the top and the testbench
package frf_pkg;

  // ring and staging sizes, both powers of two
  localparam int RING_BYTES  = 4096;
  localparam int STAGE_BYTES = 512;
  localparam int RING_AW     = $clog2(RING_BYTES);
  localparam int STAGE_AW    = $clog2(STAGE_BYTES);
  localparam int FCNT_W      = $clog2(RING_BYTES + 1);
  localparam int SCNT_W      = $clog2(STAGE_BYTES + 1);

  localparam int FUNC_W  = 2;
  localparam int FLAGS_W = 16;
  localparam int LEN_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int OFS_W   = 12;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_FRAG  = 2'd0,
    FN_POP   = 2'd1,
    FN_PEEK  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_BEGIN   = 3'd1,
    ST_BAD_SYNC   = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_STAGE_FULL = 3'd4,
    ST_FIFO_FULL  = 3'd5,
    ST_FIFO_EMPTY = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_MASK    = 2'd0,
    CFG_SYNC_PATTERN = 2'd1,
    CFG_BEGIN_FLAG   = 2'd2,
    CFG_END_FLAG     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] sync_mask;
    logic [CFG_W-1:0] sync_pattern;
    logic [CFG_W-1:0] begin_flag;
    logic [CFG_W-1:0] end_flag;
  } cfg_t;

  typedef struct packed {
    func_t              func;
    logic [FLAGS_W-1:0] frag_flags;
    logic [LEN_W-1:0]   frag_len;
    logic [BYTE_W-1:0]  data_byte;
    logic               first_of_frag;
    logic               last_of_frag;
    logic [OFS_W-1:0]   peek_offset;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  read_byte;
    logic               message_done;
    logic [FCNT_W-1:0]  fifo_count;
    logic [SCNT_W-1:0]  staged_count;
  } res_t;

endpackage

@@ rtl/core/frf_if.sv @@
// frf_if: request and result channel interfaces, valid/ready handshake
// depends on frf_pkg for field widths
interface frf_in_if import frf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [FLAGS_W-1:0] frag_flags;
  logic [LEN_W-1:0]   frag_len;
  logic [BYTE_W-1:0]  data_byte;
  logic               first_of_frag;
  logic               last_of_frag;
  logic [OFS_W-1:0]   peek_offset;

  modport source (output valid, func, frag_flags, frag_len, data_byte, first_of_frag,
                  last_of_frag, peek_offset, input ready);
  modport sink (input valid, func, frag_flags, frag_len, data_byte, first_of_frag,
                last_of_frag, peek_offset, output ready);
endinterface

interface frf_out_if import frf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] read_byte;
  logic              message_done;
  logic [FCNT_W-1:0] fifo_count;
  logic [SCNT_W-1:0] staged_count;

  modport source (output valid, status, read_byte, message_done, fifo_count, staged_count,
                  input ready);
  modport sink (input valid, status, read_byte, message_done, fifo_count, staged_count,
                output ready);
endinterface

@@ rtl/core/frf_ram.sv @@
// frf_ram: generic single write port, single read port ram with registered read data
// no dependencies; contents undefined until written
module frf_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/frf_ctrl.sv @@
// frf_ctrl: request sequencer; fragment checks, staging writes, commit copy,
// pop/peek reads and fifo pointers; uses frf_pkg, drives the two frf_ram instances
module frf_ctrl import frf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  item_t               in_item,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res,
  output logic                st_we,
  output logic [STAGE_AW-1:0] st_waddr,
  output logic [BYTE_W-1:0]   st_wdata,
  output logic [STAGE_AW-1:0] st_raddr,
  input  logic [BYTE_W-1:0]   st_rdata,
  output logic                rg_we,
  output logic [RING_AW-1:0]  rg_waddr,
  output logic [BYTE_W-1:0]   rg_wdata,
  output logic [RING_AW-1:0]  rg_raddr,
  input  logic [BYTE_W-1:0]   rg_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_COPY,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  item_t               item_r, item_nxt;
  status_t             status_r, status_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                done_r, done_nxt;
  logic [SCNT_W-1:0]   sc_r, sc_nxt;
  logic                eb_r, eb_nxt;
  logic                disc_r, disc_nxt;
  logic [RING_AW-1:0]  wp_r, wp_nxt;
  logic [RING_AW-1:0]  rp_r, rp_nxt;
  logic [FCNT_W-1:0]   held_r, held_nxt;
  logic [SCNT_W-1:0]   copy_rd_r, copy_rd_nxt;
  logic [SCNT_W-1:0]   copy_len_r, copy_len_nxt;
  logic                pend_r, pend_nxt;

  logic                fail;
  logic                do_stage;
  status_t             fstat;
  logic [SCNT_W-1:0]   stage_room;
  logic [FCNT_W-1:0]   ring_room;
  logic [SCNT_W-1:0]   sc_plus;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res       = '{status: status_r, read_byte: byte_r, message_done: done_r,
                       fifo_count: held_r, staged_count: sc_r};

  assign st_waddr   = sc_r[STAGE_AW-1:0];
  assign st_wdata   = item_r.data_byte;
  assign st_raddr   = copy_rd_r[STAGE_AW-1:0];
  assign rg_waddr   = wp_r;
  assign rg_wdata   = st_rdata;
  assign stage_room = SCNT_W'(STAGE_BYTES) - sc_r;
  assign ring_room  = FCNT_W'(RING_BYTES) - held_r;
  assign sc_plus    = sc_r + SCNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    status_nxt   = status_r;
    byte_nxt     = byte_r;
    done_nxt     = done_r;
    sc_nxt       = sc_r;
    eb_nxt       = eb_r;
    disc_nxt     = disc_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    held_nxt     = held_r;
    copy_rd_nxt  = copy_rd_r;
    copy_len_nxt = copy_len_r;
    pend_nxt     = pend_r;
    st_we        = 1'b0;
    rg_we        = 1'b0;
    rg_raddr     = rp_r;
    fail         = 1'b0;
    do_stage     = 1'b0;
    fstat        = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = ST_OK;
        byte_nxt   = '0;
        done_nxt   = 1'b0;
        state_nxt  = S_OUT;
        case (item_r.func)
          FN_FRAG: begin
            if (item_r.first_of_frag) begin
              disc_nxt = 1'b0;
              if (eb_r) begin
                eb_nxt = 1'b0;
                if ((item_r.frag_flags & cfg.begin_flag) == '0) begin
                  fail  = 1'b1;
                  fstat = ST_NO_BEGIN;
                end
              end
              if (!fail && (item_r.frag_flags & cfg.sync_mask) != cfg.sync_pattern) begin
                fail  = 1'b1;
                fstat = ST_BAD_SYNC;
              end
              if (!fail && item_r.frag_len == '0) begin
                fail  = 1'b1;
                fstat = ST_EMPTY;
              end
              if (!fail && 32'(stage_room) < 32'(item_r.frag_len)) begin
                fail  = 1'b1;
                fstat = ST_STAGE_FULL;
              end
              do_stage = !fail;
            end else if (disc_r) begin
              // rest of a rejected fragment
              if (item_r.last_of_frag) begin
                disc_nxt = 1'b0;
              end
            end else if (!eb_r) begin
              do_stage = 1'b1;
            end

            // overlong fragment runs past the staging buffer
            if (do_stage && sc_r == SCNT_W'(STAGE_BYTES)) begin
              do_stage = 1'b0;
              fail     = 1'b1;
              fstat    = ST_STAGE_FULL;
            end

            if (fail) begin
              sc_nxt   = '0;
              eb_nxt   = 1'b1;
              disc_nxt = !item_r.last_of_frag;
            end
            status_nxt = fstat;

            if (do_stage) begin
              st_we  = 1'b1;
              sc_nxt = sc_plus;
              if (item_r.last_of_frag && (item_r.frag_flags & cfg.end_flag) != '0) begin
                sc_nxt = '0;
                eb_nxt = 1'b1;
                if (ring_room >= FCNT_W'(sc_plus)) begin
                  held_nxt     = held_r + FCNT_W'(sc_plus);
                  done_nxt     = 1'b1;
                  copy_len_nxt = sc_plus;
                  copy_rd_nxt  = '0;
                  pend_nxt     = 1'b0;
                  state_nxt    = S_COPY;
                end else begin
                  status_nxt = ST_FIFO_FULL;
                end
              end
            end
          end

          FN_POP: begin
            if (held_r == '0) begin
              status_nxt = ST_FIFO_EMPTY;
            end else begin
              rg_raddr  = rp_r;
              rp_nxt    = rp_r + RING_AW'(1);
              held_nxt  = held_r - FCNT_W'(1);
              state_nxt = S_READ;
            end
          end

          FN_PEEK: begin
            if (32'(item_r.peek_offset) >= 32'(held_r)) begin
              status_nxt = ST_FIFO_EMPTY;
            end else begin
              // offset is below the count here, so it fits the ring index
              rg_raddr  = rp_r + RING_AW'(item_r.peek_offset);
              state_nxt = S_READ;
            end
          end

          FN_CLEAR: begin
            wp_nxt   = '0;
            rp_nxt   = '0;
            held_nxt = '0;
          end

          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end

      S_READ: begin
        byte_nxt  = rg_rdata;
        state_nxt = S_OUT;
      end

      S_COPY: begin
        // staging read issued in the cycle before the matching ring write
        if (copy_rd_r != copy_len_r) begin
          copy_rd_nxt = copy_rd_r + SCNT_W'(1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          rg_we  = 1'b1;
          wp_nxt = wp_r + RING_AW'(1);
        end
        if (copy_rd_r == copy_len_r && !pend_r) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sc_r    <= '0;
      eb_r    <= 1'b1;
      disc_r  <= 1'b0;
      wp_r    <= '0;
      rp_r    <= '0;
      held_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sc_r    <= sc_nxt;
      eb_r    <= eb_nxt;
      disc_r  <= disc_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      held_r  <= held_nxt;
      pend_r  <= pend_nxt;
    end
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    byte_r     <= byte_nxt;
    done_r     <= done_nxt;
    copy_rd_r  <= copy_rd_nxt;
    copy_len_r <= copy_len_nxt;
  end

endmodule

@@ rtl/core/fragment_reassembly_fifo.sv @@
// fragment_reassembly_fifo: one request at a time, next request taken as the result leaves
// fragment byte, clear and a pop or peek that finds no byte pass from exec straight to the
// output state, a pop or peek that reads the ring goes through a ring read state first; a
// committed message runs the staging-to-ring copy first; no new request is taken meanwhile
// a result waiting in the output register does not stop the next request being accepted
// synchronous active-low reset clears pointers, counts and config; ram contents are kept
module fragment_reassembly_fifo import frf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  frf_in_if.sink               in_ch,
  frf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t                cfg_r, cfg_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;
  item_t               in_item;
  logic                res_valid;
  logic                res_ready;
  res_t                res;
  logic                st_we;
  logic [STAGE_AW-1:0] st_waddr;
  logic [BYTE_W-1:0]   st_wdata;
  logic [STAGE_AW-1:0] st_raddr;
  logic [BYTE_W-1:0]   st_rdata;
  logic                rg_we;
  logic [RING_AW-1:0]  rg_waddr;
  logic [BYTE_W-1:0]   rg_wdata;
  logic [RING_AW-1:0]  rg_raddr;
  logic [BYTE_W-1:0]   rg_rdata;

  assign in_item = '{func: func_t'(in_ch.func), frag_flags: in_ch.frag_flags,
                     frag_len: in_ch.frag_len, data_byte: in_ch.data_byte,
                     first_of_frag: in_ch.first_of_frag, last_of_frag: in_ch.last_of_frag,
                     peek_offset: in_ch.peek_offset};

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_SYNC_MASK:    cfg_nxt.sync_mask    = cfg_wdata;
        CFG_SYNC_PATTERN: cfg_nxt.sync_pattern = cfg_wdata;
        CFG_BEGIN_FLAG:   cfg_nxt.begin_flag   = cfg_wdata;
        CFG_END_FLAG:     cfg_nxt.end_flag     = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // output register frees up as soon as the sink takes the result
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.read_byte    = out_res_r.read_byte;
  assign out_ch.message_done = out_res_r.message_done;
  assign out_ch.fifo_count   = out_res_r.fifo_count;
  assign out_ch.staged_count = out_res_r.staged_count;

  frf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata),
    .rg_we     (rg_we),
    .rg_waddr  (rg_waddr),
    .rg_wdata  (rg_wdata),
    .rg_raddr  (rg_raddr),
    .rg_rdata  (rg_rdata)
  );

  frf_ram #(.DEPTH(STAGE_BYTES), .WIDTH(BYTE_W)) u_stage_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  frf_ram #(.DEPTH(RING_BYTES), .WIDTH(BYTE_W)) u_ring_ram (
    .clk   (clk),
    .we    (rg_we),
    .waddr (rg_waddr),
    .wdata (rg_wdata),
    .raddr (rg_raddr),
    .rdata (rg_rdata)
  );

endmodule

@@ tb/testbench.sv @@
// testbench for fragment_reassembly_fifo: directed requests and randomized traffic under
// four flag setups, checked against an in-bench byte-level predictor
// depends on frf_pkg, frf_if and the fragment_reassembly_fifo rtl
module testbench;
  import frf_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  frf_in_if  in_ch ();
  frf_out_if out_ch ();

  fragment_reassembly_fifo dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // requests waiting to be sent and results predicted for accepted requests
  item_t pending_requests[$];
  res_t  expected_results[$];
  int issued = 0;
  int checked = 0;
  int mismatches = 0;
  int commits = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor state
  cfg_t       cur_cfg;
  logic [7:0] stage_mem [STAGE_BYTES];
  logic [7:0] ring_mem [RING_BYTES];
  int         stage_n;
  int         held_n;
  int         wr_ptr;
  int         rd_ptr;
  bit         want_begin;
  bit         skip_rest;

  function automatic void abort_message(bit last);
    stage_n = 0;
    want_begin = 1'b1;
    skip_rest = !last;
  endfunction

  function automatic status_t take_fragment_byte(item_t it, output bit done);
    int k;
    status_t st;
    done = 1'b0;
    if (it.first_of_frag) begin
      skip_rest = 1'b0;
      if (want_begin) begin
        want_begin = 1'b0;
        if ((it.frag_flags & cur_cfg.begin_flag) == '0) begin
          abort_message(it.last_of_frag);
          return ST_NO_BEGIN;
        end
      end
      if ((it.frag_flags & cur_cfg.sync_mask) != cur_cfg.sync_pattern) begin
        abort_message(it.last_of_frag);
        return ST_BAD_SYNC;
      end
      if (it.frag_len == '0) begin
        abort_message(it.last_of_frag);
        return ST_EMPTY;
      end
      if (STAGE_BYTES - stage_n < int'(it.frag_len)) begin
        abort_message(it.last_of_frag);
        return ST_STAGE_FULL;
      end
    end else begin
      if (skip_rest) begin
        if (it.last_of_frag) skip_rest = 1'b0;
        return ST_OK;
      end
      // stray byte outside any message
      if (want_begin) return ST_OK;
    end
    // more bytes than the fragment announced can still overrun staging
    if (stage_n >= STAGE_BYTES) begin
      abort_message(it.last_of_frag);
      return ST_STAGE_FULL;
    end
    stage_mem[stage_n] = it.data_byte;
    stage_n++;
    if (it.last_of_frag && (it.frag_flags & cur_cfg.end_flag) != '0) begin
      st = ST_OK;
      if (RING_BYTES - held_n >= stage_n) begin
        for (k = 0; k < stage_n; k++) begin
          ring_mem[wr_ptr] = stage_mem[k];
          wr_ptr = (wr_ptr + 1) % RING_BYTES;
        end
        held_n += stage_n;
        done = 1'b1;
        commits++;
      end else begin
        st = ST_FIFO_FULL;
      end
      stage_n = 0;
      want_begin = 1'b1;
      return st;
    end
    return ST_OK;
  endfunction

  function automatic res_t predict_result(item_t it);
    res_t r;
    bit done;
    r = '0;
    r.status = ST_OK;
    case (it.func)
      FN_FRAG: begin
        r.status = take_fragment_byte(it, done);
        r.message_done = done;
      end
      FN_POP: begin
        if (held_n == 0) begin
          r.status = ST_FIFO_EMPTY;
        end else begin
          r.read_byte = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % RING_BYTES;
          held_n--;
        end
      end
      FN_PEEK: begin
        if (int'(it.peek_offset) >= held_n) r.status = ST_FIFO_EMPTY;
        else r.read_byte = ring_mem[(rd_ptr + int'(it.peek_offset)) % RING_BYTES];
      end
      default: begin
        wr_ptr = 0;
        rd_ptr = 0;
        held_n = 0;
      end
    endcase
    r.fifo_count = FCNT_W'(held_n);
    r.staged_count = SCNT_W'(stage_n);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // driver: next request goes out once the current one is taken
  always @(posedge clk) begin : driver
    item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_requests.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.func          <= nxt.func;
        in_ch.frag_flags    <= nxt.frag_flags;
        in_ch.frag_len      <= nxt.frag_len;
        in_ch.data_byte     <= nxt.data_byte;
        in_ch.first_of_frag <= nxt.first_of_frag;
        in_ch.last_of_frag  <= nxt.last_of_frag;
        in_ch.peek_offset   <= nxt.peek_offset;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted requests, compare accepted results in order
  always @(posedge clk) begin : monitor
    item_t seen;
    res_t  want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.func          = func_t'(in_ch.func);
        seen.frag_flags    = in_ch.frag_flags;
        seen.frag_len      = in_ch.frag_len;
        seen.data_byte     = in_ch.data_byte;
        seen.first_of_frag = in_ch.first_of_frag;
        seen.last_of_frag  = in_ch.last_of_frag;
        seen.peek_offset   = in_ch.peek_offset;
        expected_results.push_back(predict_result(seen));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("read_byte", want.read_byte, out_ch.read_byte);
          check_field("message_done", want.message_done, out_ch.message_done);
          check_field("fifo_count", want.fifo_count, out_ch.fifo_count);
          check_field("staged_count", want.staged_count, out_ch.staged_count);
          checked++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push(item_t it);
    pending_requests.push_back(it);
    issued++;
  endtask

  function automatic item_t frag_item(logic [15:0] flags, logic [15:0] len, logic [7:0] b,
                                      bit first, bit last);
    item_t it;
    it.func          = FN_FRAG;
    it.frag_flags    = flags;
    it.frag_len      = len;
    it.data_byte     = b;
    it.first_of_frag = first;
    it.last_of_frag  = last;
    it.peek_offset   = 12'($urandom);
    return it;
  endfunction

  function automatic item_t op_item(func_t f, logic [11:0] ofs);
    item_t it;
    it.func          = f;
    it.frag_flags    = 16'($urandom);
    it.frag_len      = 16'($urandom);
    it.data_byte     = 8'($urandom);
    it.first_of_frag = 1'($urandom);
    it.last_of_frag  = 1'($urandom);
    it.peek_offset   = ofs;
    return it;
  endfunction

  // flags that pass the sync check under the current setup
  function automatic logic [15:0] good_flags(bit first, bit last);
    logic [15:0] f;
    f = 16'($urandom);
    if (first) f |= cur_cfg.begin_flag;
    if (last) f |= cur_cfg.end_flag;
    else f &= ~cur_cfg.end_flag;
    f = (f & ~cur_cfg.sync_mask) | (cur_cfg.sync_pattern & cur_cfg.sync_mask);
    return f;
  endfunction

  task automatic push_fragment(logic [15:0] flags, logic [15:0] len, int nbytes);
    int i;
    for (i = 0; i < nbytes; i++)
      push(frag_item(flags, len, 8'($urandom), i == 0, i == nbytes - 1));
  endtask

  task automatic push_message();
    int nf;
    int f;
    int len;
    nf = $urandom_range(1, 3);
    for (f = 0; f < nf; f++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      push_fragment(good_flags(f == 0, f == nf - 1), 16'(len), len);
    end
  endtask

  task automatic push_broken();
    logic [$bits(item_t)-1:0] raw;
    logic [15:0] flags;
    int len;
    case ($urandom_range(5))
      0: begin
        raw = $bits(item_t)'({$urandom, $urandom});
        push(item_t'(raw));
      end
      1: begin
        // fragment cut short, next fragment starts early
        len = $urandom_range(2, 8);
        push_fragment(good_flags(1'b1, 1'($urandom)), 16'(len), $urandom_range(1, len - 1));
      end
      2: push_fragment(good_flags(1'b1, 1'b1) & ~cur_cfg.begin_flag, 16'd2, 2);
      3: begin
        flags = good_flags(1'b1, 1'b1);
        if (cur_cfg.sync_mask != '0) flags ^= cur_cfg.sync_mask & (~cur_cfg.sync_mask + 16'd1);
        else flags = 16'($urandom);
        push_fragment(flags, 16'd1, 1);
      end
      4: push_fragment(good_flags(1'b1, 1'b1), 16'd0, $urandom_range(1, 2));
      default: begin
        if ($urandom_range(1)) push_fragment(good_flags(1'b1, 1'b0),
                                             16'($urandom_range(513, 65535)), 2);
        else push(frag_item(16'($urandom), 16'($urandom), 8'($urandom), 1'b0,
                            1'($urandom)));
      end
    endcase
  endtask

  task automatic random_traffic(int count);
    int start;
    int pick;
    int n;
    start = issued;
    while (issued - start < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_message();
      end else if (pick < 70) begin
        n = $urandom_range(1, 12);
        repeat (n) push(op_item(FN_POP, 12'($urandom)));
      end else if (pick < 78) begin
        push(op_item(FN_PEEK, ($urandom_range(3) == 0) ? 12'($urandom)
                                                       : 12'($urandom_range(15))));
      end else if (pick < 81) begin
        push(op_item(FN_CLEAR, 12'($urandom)));
      end else begin
        push_broken();
      end
    end
  endtask

  // wait for every result, then give the block time to go quiet
  task automatic settle();
    while (checked != issued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_setup(cfg_t c);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SYNC_MASK;
    cfg_wdata <= c.sync_mask;
    @(posedge clk);
    cfg_idx   <= CFG_SYNC_PATTERN;
    cfg_wdata <= c.sync_pattern;
    @(posedge clk);
    cfg_idx   <= CFG_BEGIN_FLAG;
    cfg_wdata <= c.begin_flag;
    @(posedge clk);
    cfg_idx   <= CFG_END_FLAG;
    cfg_wdata <= c.end_flag;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.func          = FN_FRAG;
    in_ch.frag_flags    = '0;
    in_ch.frag_len      = '0;
    in_ch.data_byte     = '0;
    in_ch.first_of_frag = 1'b0;
    in_ch.last_of_frag  = 1'b0;
    in_ch.peek_offset   = '0;
    out_ch.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_SYNC_MASK;
    cfg_wdata           = '0;
    cur_cfg             = '0;
    stage_n             = 0;
    held_n              = 0;
    wr_ptr              = 0;
    rd_ptr              = 0;
    want_begin          = 1'b1;
    skip_rest           = 1'b0;
    rst_n               = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup has no begin bits, so any fragment is missing its begin
    push(frag_item(16'hFFFF, 16'd1, 8'hFF, 1'b1, 1'b1));
    push(op_item(FN_POP, 12'h000));
    push(op_item(FN_PEEK, 12'h000));
    settle();
    load_setup('{16'hF000, 16'hA000, 16'h0001, 16'h0002});
    push(frag_item(16'hA003, 16'd4, 8'h5A, 1'b0, 1'b0));
    push(frag_item(16'hA000, 16'd3, 8'h11, 1'b1, 1'b0));
    push(frag_item(16'hA000, 16'd3, 8'h22, 1'b0, 1'b0));
    push(frag_item(16'hA000, 16'd3, 8'h33, 1'b0, 1'b1));
    push(frag_item(16'h0001, 16'd1, 8'h44, 1'b1, 1'b1));
    push(frag_item(16'hA001, 16'd0, 8'h55, 1'b1, 1'b1));
    push(frag_item(16'hA001, 16'hFFFF, 8'h66, 1'b1, 1'b0));
    push(frag_item(16'hA001, 16'hFFFF, 8'h77, 1'b0, 1'b1));
    push(frag_item(16'hA001, 16'd2, 8'h00, 1'b1, 1'b0));
    push(frag_item(16'hA001, 16'd2, 8'hFF, 1'b0, 1'b1));
    push(frag_item(16'hA002, 16'd3, 8'h81, 1'b1, 1'b0));
    push(frag_item(16'hA002, 16'd3, 8'h7E, 1'b0, 1'b0));
    push(frag_item(16'hA002, 16'd3, 8'hC3, 1'b0, 1'b1));
    push(op_item(FN_PEEK, 12'd4));
    push(op_item(FN_PEEK, 12'hFFF));
    push(op_item(FN_POP, 12'h000));
    // clear in the middle of a message keeps what is staged
    push(frag_item(16'hA003, 16'd2, 8'h3C, 1'b1, 1'b0));
    push(op_item(FN_CLEAR, 12'h000));
    push(frag_item(16'hA003, 16'd2, 8'hA5, 1'b0, 1'b1));
    push(op_item(FN_CLEAR, 12'h000));
    settle();

    random_traffic(100);
    settle();
    random_traffic(100);
    settle();

    load_setup('{16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000});
    send_idle_pct = 74;
    random_traffic(100);
    settle();
    random_traffic(100);
    settle();

    load_setup('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF});
    send_idle_pct = 0;
    recv_stall_pct = 74;
    random_traffic(100);
    settle();
    random_traffic(100);
    settle();

    load_setup('{16'h00F0, 16'h0050, 16'h0100, 16'h0200});
    send_idle_pct = 36;
    recv_stall_pct = 36;
    random_traffic(100);
    settle();
    random_traffic(100);
    settle();

    repeat (40) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      mismatches++;
    end
    $display("sent %0d requests over five flag setups and four idling mixes", issued);
    $display("checked %0d results, %0d messages committed, %0d mismatches",
             checked, commits, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
